// ===== rtl/sapg_pkg.sv =====
// ----------------------------------------------------------------------------
// sapg_pkg: shared types and constants of the servo pulse generator
// Transaction payloads, command kinds, register indexes, reset values and
// the fixed-point constants of the angle-to-width mapping.
// ----------------------------------------------------------------------------
package sapg_pkg;

  // Number of addressable servo slots (the servo field is two bits wide).
  localparam int unsigned SERVO_SLOTS = 4;

  // Command kinds carried by an input transaction.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WIDTH  = 2'd1,
    KIND_ANGLE  = 2'd2,
    KIND_CENTER = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_MIN      = 3'd1,
    REG_MAX      = 3'd2,
    REG_CENTER_A = 3'd3,
    REG_CENTER_B = 3'd4,
    REG_CENTER_C = 3'd5,
    REG_CENTER_D = 3'd6,
    REG_REVERSE  = 3'd7
  } reg_idx_t;

  // Reset values.
  localparam logic [15:0] PERIOD_RST = 16'd20000;
  localparam logic [15:0] MIN_RST    = 16'd1300;
  localparam logic [15:0] MAX_RST    = 16'd1700;
  localparam logic [15:0] CENTER_RST = 16'd1500;
  localparam logic [15:0] WIDTH_RST  = 16'd1500;

  // Angle mapping: +-90 degrees in Q8.8 and the divisor 2 * 23040.
  localparam logic signed [15:0] ANGLE_LIMIT  = 16'sd23040;
  localparam logic signed [34:0] SCALE_DIV    = 35'sd46080;
  localparam logic signed [34:0] ROUND_HALF   = 35'sd23040;
  // 46080 = 1024 * 45: shift by 10, then divide by 45 with a reciprocal.
  localparam int unsigned        DIV_SHIFT    = 10;
  localparam logic [22:0]        DIV_ODD      = 23'd45;
  localparam logic [18:0]        RECIP_ODD    = 19'd372827; // floor(2^24 / 45)
  localparam int unsigned        RECIP_SHIFT  = 24;

  // Input transaction.
  typedef struct packed {
    kind_t              kind;
    logic [1:0]         servo;
    logic [15:0]        pulse_us;
    logic signed [15:0] angle;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [3:0]  pwm_lines;
    logic        frame_start;
    logic [15:0] pending_out;
  } out_item_t;

  // Pipeline stage after the angle multiply.
  typedef struct packed {
    kind_t              kind;
    logic [1:0]         servo;
    logic [15:0]        raw_width;
    logic [15:0]        center;
    logic signed [32:0] prod;
  } prod_stage_t;

  // Pipeline stage after the reciprocal multiply.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  servo;
    logic [15:0] raw_width;
    logic [22:0] scaled;
    logic [17:0] quot_est;
  } quot_stage_t;

endpackage

// ===== rtl/servo_angle_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// servo_angle_pwm_generator: four-channel RC servo pulse generator
// Microsecond tick transactions advance a frame counter and produce the
// servo line levels; command transactions set the pending pulse widths.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions (in_valid/in_ready/in_data) are either one-microsecond
// ticks or commands that set a width, map a Q8.8 angle or re-center a servo.
// Every input transaction yields exactly one result transaction on
// out_valid/out_ready/out_data, in order: line levels, frame start flag and
// the addressed servo's pending width.
// A transaction passes the stage 1, 2 and 3 registers, then the output register.
// One transaction is accepted every cycle while the receiver does not stall;
// the angle path is a three-stage pipeline (clamp and multiply, reciprocal
// multiply, correction and state update), each stage holding one transaction.
// When the receiver stalls, the result waits in the output register and the
// pipeline stages behind it keep filling until all are occupied; in_ready
// then drops.
// Configuration writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are taken
// in any cycle and belong between transactions while the block is idle.
// Synchronous reset loads the register defaults, sets every width to 1500,
// clears the counter and the lines and empties the pipeline.
// ----------------------------------------------------------------------------
module servo_angle_pwm_generator #(
  parameter int unsigned SERVO_NUM = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sapg_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sapg_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import sapg_pkg::*;

  // Configuration registers.
  logic [15:0] period_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [15:0] center_r [SERVO_SLOTS];
  logic [3:0]  reverse_r;

  // Generator state.
  logic [15:0] frame_count_r;
  logic [15:0] frame_count_nxt;
  logic [15:0] pending_r [SERVO_SLOTS];
  logic [15:0] active_r  [SERVO_SLOTS];
  logic [3:0]  line_levels_r;
  logic [3:0]  line_levels_nxt;

  // Pipeline registers and handshake.
  logic        s1_valid_r;
  in_item_t    s1_r;
  logic        s2_valid_r;
  prod_stage_t s2_r;
  prod_stage_t s2_nxt;
  logic        s3_valid_r;
  quot_stage_t s3_r;
  quot_stage_t s3_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic        out_valid_r;

  logic        out_stall;
  logic        s3_ready;
  logic        s2_ready;
  logic        s1_ready;
  logic        commit;

  // Configuration port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RST;
      min_r     <= MIN_RST;
      max_r     <= MAX_RST;
      reverse_r <= '0;
      for (int i = 0; i < SERVO_SLOTS; i++) begin
        center_r[i] <= CENTER_RST;
      end
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD:   period_r    <= cfg_data;
        REG_MIN:      min_r       <= cfg_data;
        REG_MAX:      max_r       <= cfg_data;
        REG_CENTER_A: center_r[0] <= cfg_data;
        REG_CENTER_B: center_r[1] <= cfg_data;
        REG_CENTER_C: center_r[2] <= cfg_data;
        REG_CENTER_D: center_r[3] <= cfg_data;
        REG_REVERSE:  reverse_r   <= cfg_data[3:0];
        default:      period_r    <= period_r;
      endcase
    end
  end

  // Backpressure chain: a stage takes new data when it is empty or drains.
  assign out_stall = out_valid_r && !out_ready;
  assign s3_ready  = !s3_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_ready  = s1_ready;
  assign commit    = s3_valid_r && !out_stall;

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r <= in_data;
    end
  end

  // Stage 1 to 2: clamp and orient the angle, pick the span, multiply.
  always_comb begin
    logic signed [15:0] ang_clamped;
    logic signed [15:0] ang_dir;
    logic signed [16:0] span;
    logic [15:0]        center;

    center = center_r[s1_r.servo];
    if (s1_r.angle > ANGLE_LIMIT) begin
      ang_clamped = ANGLE_LIMIT;
    end else if (s1_r.angle < -ANGLE_LIMIT) begin
      ang_clamped = -ANGLE_LIMIT;
    end else begin
      ang_clamped = s1_r.angle;
    end
    ang_dir = reverse_r[s1_r.servo] ? -ang_clamped : ang_clamped;

    if (ang_dir >= 0) begin
      span = $signed({1'b0, max_r}) - $signed({1'b0, center});
    end else begin
      span = $signed({1'b0, center}) - $signed({1'b0, min_r});
    end

    s2_nxt.kind      = s1_r.kind;
    s2_nxt.servo     = s1_r.servo;
    s2_nxt.raw_width = (s1_r.kind == KIND_WIDTH) ? s1_r.pulse_us : center;
    s2_nxt.center    = center;
    s2_nxt.prod      = 33'(ang_dir) * 33'(span);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage 2 to 3: build the rounded numerator, divide by 1024, then
  // estimate the quotient by 45 with a reciprocal multiply.
  always_comb begin
    logic signed [34:0] numer;
    logic [22:0]        scaled;
    logic [41:0]        recip_prod;

    numer = $signed({19'd0, s2_r.center}) * SCALE_DIV
          + 35'(s2_r.prod) * 35'sd2 + ROUND_HALF;
    // A negative numerator gives a scaled value of zero.
    scaled = numer[34] ? '0 : numer[DIV_SHIFT +: 23];
    recip_prod = 42'(scaled) * 42'(RECIP_ODD);

    s3_nxt.kind      = s2_r.kind;
    s3_nxt.servo     = s2_r.servo;
    s3_nxt.raw_width = s2_r.raw_width;
    s3_nxt.scaled    = scaled;
    s3_nxt.quot_est  = recip_prod[RECIP_SHIFT +: 18];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 3: correct the quotient, clamp the width, run the frame logic.
  logic        servo_ok;
  logic        frame_begin;
  logic [15:0] width_new;

  assign servo_ok    = 32'(s3_r.servo) < SERVO_NUM;
  assign frame_begin = (frame_count_r == '0);

  always_comb begin
    logic [22:0] remainder;
    logic [17:0] quot;
    logic [15:0] width_pre;

    // The reciprocal estimate is low by at most one.
    remainder = s3_r.scaled - 23'(s3_r.quot_est) * DIV_ODD;
    quot      = (remainder >= DIV_ODD) ? s3_r.quot_est + 18'd1 : s3_r.quot_est;

    if (s3_r.kind == KIND_ANGLE) begin
      width_pre = (quot > 18'd65535) ? 16'hFFFF : quot[15:0];
    end else begin
      width_pre = s3_r.raw_width;
    end

    // Below the minimum wins over above the maximum when limits cross.
    if (width_pre < min_r) begin
      width_new = min_r;
    end else if (width_pre > max_r) begin
      width_new = max_r;
    end else begin
      width_new = width_pre;
    end
  end

  // Frame counter and line levels for a tick.
  always_comb begin
    logic [16:0] count_inc;
    logic [16:0] period_eff;

    period_eff = (period_r == '0) ? 17'd1 : {1'b0, period_r};
    count_inc  = {1'b0, frame_count_r} + 17'd1;
    frame_count_nxt = (count_inc >= period_eff) ? '0 : count_inc[15:0];

    line_levels_nxt = '0;
    for (int i = 0; i < SERVO_SLOTS; i++) begin
      if (i < SERVO_NUM) begin
        line_levels_nxt[i] = frame_begin ? (frame_count_r < pending_r[i])
                                         : (frame_count_r < active_r[i]);
      end
    end
  end

  // Result assembly.
  always_comb begin
    if (s3_r.kind == KIND_TICK) begin
      out_nxt.pwm_lines   = line_levels_nxt;
      out_nxt.frame_start = frame_begin;
      out_nxt.pending_out = servo_ok ? pending_r[s3_r.servo] : '0;
    end else begin
      out_nxt.pwm_lines   = line_levels_r;
      out_nxt.frame_start = 1'b0;
      out_nxt.pending_out = servo_ok ? width_new : '0;
    end
  end

  // State update at commit of each transaction, in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      line_levels_r <= '0;
      for (int i = 0; i < SERVO_SLOTS; i++) begin
        pending_r[i] <= WIDTH_RST;
        active_r[i]  <= WIDTH_RST;
      end
    end else if (commit) begin
      if (s3_r.kind == KIND_TICK) begin
        frame_count_r <= frame_count_nxt;
        line_levels_r <= line_levels_nxt;
        if (frame_begin) begin
          for (int i = 0; i < SERVO_SLOTS; i++) begin
            active_r[i] <= pending_r[i];
          end
        end
      end else if (servo_ok) begin
        pending_r[s3_r.servo] <= width_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_stall) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
